@@ rtl/core/plpb_pkg.sv @@
// ----------------------------------------------------------------------------
// plpb_pkg
// Shared types and constants of the particle plane bounce pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package plpb_pkg;

    // Default number formats
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Configuration register index
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X    = 3'd0,
        CFG_NORMAL_Y    = 3'd1,
        CFG_NORMAL_Z    = 3'd2,
        CFG_PLANE_OFFS  = 3'd3,
        CFG_FRICTION    = 3'd4,
        CFG_RESTITUTION = 3'd5,
        CFG_DIE         = 3'd6
    } cfg_idx_t;

    // Outcome of one particle
    typedef enum logic [1:0] {
        OC_ABOVE   = 2'd0,
        OC_KILLED  = 2'd1,
        OC_AWAY    = 2'd2,
        OC_DEFLECT = 2'd3
    } outcome_t;

endpackage

`default_nettype wire

@@ rtl/core/particle_plane_bounce.sv @@
// ----------------------------------------------------------------------------
// particle_plane_bounce
// Collision response of a particle stream against one configured plane.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------
//  in      | in_valid  | in_stall  | pos_x..z, vel_x..z
//  out     | out_valid | out_stall | new_pos_x..z, new_vel_x..z, kill,
//          |           |           | outcome, saturated
//  cfg     | cfg_we    | -         | cfg_index, cfg_data
//
// One word enters per cycle unless the output word is stalled; the divider
// resolves one quotient bit per stage.
// Reset clears the stage valid bits and loads the register reset values.
// A stalled output word freezes every stage; in_stall follows that hold.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_plane_bounce
    import plpb_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [((VALUE_WIDTH > FRAC_BITS + 2) ? VALUE_WIDTH : FRAC_BITS + 2)-1:0]
                                                cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [VALUE_WIDTH-1:0]  pos_x,
    input  wire logic signed [VALUE_WIDTH-1:0]  pos_y,
    input  wire logic signed [VALUE_WIDTH-1:0]  pos_z,
    input  wire logic signed [VALUE_WIDTH-1:0]  vel_x,
    input  wire logic signed [VALUE_WIDTH-1:0]  vel_y,
    input  wire logic signed [VALUE_WIDTH-1:0]  vel_z,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [VALUE_WIDTH-1:0]       new_pos_x,
    output logic signed [VALUE_WIDTH-1:0]       new_pos_y,
    output logic signed [VALUE_WIDTH-1:0]       new_pos_z,
    output logic signed [VALUE_WIDTH-1:0]       new_vel_x,
    output logic signed [VALUE_WIDTH-1:0]       new_vel_y,
    output logic signed [VALUE_WIDTH-1:0]       new_vel_z,
    output logic                                kill,
    output logic [1:0]                          outcome,
    output logic                                saturated
);

    localparam int W    = VALUE_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = W + F + 2;
    localparam int DW   = W + F + 4;
    localparam int SW   = W + F + 5;
    localparam int NUMW = SW + F;
    localparam int CMPW = (NUMW > DW + W) ? NUMW : DW + W;
    localparam int SBW  = 3 + 6 * W;

    // ---------------- configuration registers ----------------
    logic signed [F+1:0] nrm_reg [3];
    logic signed [W-1:0] offs_reg;
    logic [F:0]          fr_reg;
    logic [F:0]          rs_reg;
    logic                die_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nrm_reg[0] <= '0;
            nrm_reg[1] <= (F+2)'(1) << F;
            nrm_reg[2] <= '0;
            offs_reg   <= '0;
            fr_reg     <= '0;
            rs_reg     <= '0;
            die_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NORMAL_X:    nrm_reg[0] <= cfg_data[F+1:0];
                CFG_NORMAL_Y:    nrm_reg[1] <= cfg_data[F+1:0];
                CFG_NORMAL_Z:    nrm_reg[2] <= cfg_data[F+1:0];
                CFG_PLANE_OFFS:  offs_reg   <= cfg_data[W-1:0];
                CFG_FRICTION:    fr_reg     <= cfg_data[F:0];
                CFG_RESTITUTION: rs_reg     <= cfg_data[F:0];
                CFG_DIE:         die_reg    <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // ---------------- global advance ----------------
    logic adv;

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // ---------------- stage 1: normal products ----------------
    logic signed [W-1:0]  p_in [3];
    logic signed [W-1:0]  v_in [3];
    logic                 s1_vld_reg;
    logic signed [PW-1:0] pp_reg [3];
    logic signed [PW-1:0] pv_reg [3];
    logic signed [W-1:0]  p1_reg [3];
    logic signed [W-1:0]  v1_reg [3];

    assign p_in[0] = pos_x;
    assign p_in[1] = pos_y;
    assign p_in[2] = pos_z;
    assign v_in[0] = vel_x;
    assign v_in[1] = vel_y;
    assign v_in[2] = vel_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pp_reg[i] <= nrm_reg[i] * p_in[i];
                pv_reg[i] <= nrm_reg[i] * v_in[i];
            end
            p1_reg <= p_in;
            v1_reg <= v_in;
        end
    end

    // ---------------- stage 2: side, speed and outcome ----------------
    logic signed [SW-1:0] side_c;
    logic signed [SW-1:0] nside_c;
    logic signed [SW-1:0] offs_ext;
    logic signed [DW-1:0] speed_c;
    logic [1:0]           oc_c;
    logic                 s2_vld_reg;
    logic [NUMW-1:0]      num_reg;
    logic [DW-1:0]        den_reg;
    logic [1:0]           oc2_reg;
    logic signed [W-1:0]  p2_reg [3];
    logic signed [W-1:0]  v2_reg [3];

    always_comb
    begin
        offs_ext = SW'(offs_reg);
        side_c   = SW'(pp_reg[0]) + SW'(pp_reg[1]) + SW'(pp_reg[2]) - (offs_ext <<< F);
        nside_c  = -side_c;
        speed_c  = DW'(pv_reg[0]) + DW'(pv_reg[1]) + DW'(pv_reg[2]);
        if (!side_c[SW-1] && (side_c != '0))
        begin
            oc_c = OC_ABOVE;
        end
        else if (die_reg)
        begin
            oc_c = OC_KILLED;
        end
        else if (!speed_c[DW-1])
        begin
            oc_c = OC_AWAY;
        end
        else
        begin
            oc_c = OC_DEFLECT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg <= {nside_c, {F{1'b0}}};
            den_reg <= DW'(-speed_c);
            oc2_reg <= oc_c;
            p2_reg  <= p1_reg;
            v2_reg  <= v1_reg;
        end
    end

    // ---------------- quotient range check, then divider ----------------
    logic [CMPW-1:0] cmp_num;
    logic [CMPW-1:0] cmp_den;
    logic            ovf_c;
    logic [SBW-1:0]  sb_in;
    logic [SBW-1:0]  sb_out;
    logic            dv_vld;
    logic [W-1:0]    dv_quo;

    assign cmp_num = CMPW'(num_reg);
    assign cmp_den = CMPW'({den_reg, {W{1'b0}}});
    assign ovf_c   = (cmp_num >= cmp_den);
    assign sb_in   = {ovf_c, oc2_reg, p2_reg[0], p2_reg[1], p2_reg[2],
                      v2_reg[0], v2_reg[1], v2_reg[2]};

    plpb_divider #(
        .NUM_W  (NUMW),
        .DEN_W  (DW),
        .Q_W    (W),
        .SIDE_W (SBW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s2_vld_reg),
        .num       (num_reg),
        .den       (den_reg),
        .side_in   (sb_in),
        .out_valid (dv_vld),
        .quo       (dv_quo),
        .side_out  (sb_out)
    );

    // ---------------- response pipeline ----------------
    logic signed [W-1:0] dp [3];
    logic signed [W-1:0] dvl [3];
    logic signed [W-1:0] np_o [3];
    logic signed [W-1:0] nv_o [3];

    assign dp[0]  = sb_out[6*W-1:5*W];
    assign dp[1]  = sb_out[5*W-1:4*W];
    assign dp[2]  = sb_out[4*W-1:3*W];
    assign dvl[0] = sb_out[3*W-1:2*W];
    assign dvl[1] = sb_out[2*W-1:W];
    assign dvl[2] = sb_out[W-1:0];

    plpb_response #(
        .W (W),
        .F (F)
    ) u_resp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (dv_vld),
        .quo       (dv_quo),
        .ovf       (sb_out[SBW-1]),
        .oc_in     (sb_out[SBW-2:SBW-3]),
        .p_in      (dp),
        .v_in      (dvl),
        .nrm       (nrm_reg),
        .fr        (fr_reg),
        .rs        (rs_reg),
        .out_valid (out_valid),
        .new_pos   (np_o),
        .new_vel   (nv_o),
        .kill      (kill),
        .outcome   (outcome),
        .saturated (saturated)
    );

    assign new_pos_x = np_o[0];
    assign new_pos_y = np_o[1];
    assign new_pos_z = np_o[2];
    assign new_vel_x = nv_o[0];
    assign new_vel_y = nv_o[1];
    assign new_vel_z = nv_o[2];

endmodule

`default_nettype wire

@@ rtl/core/plpb_divider.sv @@
// ----------------------------------------------------------------------------
// plpb_divider
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// word that travels alongside each quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module plpb_divider
    import plpb_pkg::*;
#(
    parameter int NUM_W  = 85,
    parameter int DEN_W  = 52,
    parameter int Q_W    = 32,
    parameter int SIDE_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [Q_W-1:0]         quo,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic              vld_reg  [Q_W];
    logic [RW-1:0]     rem_reg  [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [Q_W-1:0]    q_reg    [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];

    for (genvar j = 0; j < Q_W; j++)
    begin : g_step
        logic              vld_in;
        logic [RW-1:0]     rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    q_in;
        logic [SIDE_W-1:0] side_i;
        logic [RW-1:0]     den_sh;
        logic [RW:0]       diff;

        if (j == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign rem_in = RW'(num);
            assign den_in = den;
            assign q_in   = '0;
            assign side_i = side_in;
        end
        else
        begin : g_later
            assign vld_in = vld_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign side_i = side_reg[j-1];
        end

        // trial subtract of the divisor aligned to this quotient bit
        assign den_sh = RW'(den_in) << (Q_W - 1 - j);
        assign diff   = {1'b0, rem_in} - {1'b0, den_sh};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[j] <= vld_in;
            end
        end

        // keep the remainder, set the quotient bit when the trial fits
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j]  <= diff[RW] ? rem_in : diff[RW-1:0];
                q_reg[j]    <= q_in | (diff[RW] ? '0 : (Q_W'(1) << (Q_W - 1 - j)));
                den_reg[j]  <= den_in;
                side_reg[j] <= side_i;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign quo       = q_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

`default_nettype wire

@@ rtl/core/plpb_response.sv @@
// ----------------------------------------------------------------------------
// plpb_response
// Back half of the bounce pipeline: crossing time clamp, position pull-back,
// restitution, normal reflection with friction, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plpb_response
    import plpb_pkg::*;
#(
    parameter int W = VALUE_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic                in_valid,
    input  wire logic [W-1:0]        quo,
    input  wire logic                ovf,
    input  wire logic [1:0]          oc_in,
    input  wire logic signed [W-1:0] p_in [3],
    input  wire logic signed [W-1:0] v_in [3],
    input  wire logic signed [F+1:0] nrm [3],
    input  wire logic [F:0]          fr,
    input  wire logic [F:0]          rs,
    output logic                     out_valid,
    output logic signed [W-1:0]      new_pos [3],
    output logic signed [W-1:0]      new_vel [3],
    output logic                     kill,
    output logic [1:0]               outcome,
    output logic                     saturated
);

    localparam int CW = 2 * W + F + 8;
    localparam logic signed [CW-1:0] VMAX_C = {{(CW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [CW-1:0] VMIN_C = ~VMAX_C;

    // clamp to the value range, flag in the top bit
    function automatic logic [W:0] sat(input logic signed [CW-1:0] a);
        logic [W:0] res;
        if (a > VMAX_C)
        begin
            res = {1'b1, VMAX_C[W-1:0]};
        end
        else if (a < VMIN_C)
        begin
            res = {1'b1, VMIN_C[W-1:0]};
        end
        else
        begin
            res = {1'b0, a[W-1:0]};
        end
        return res;
    endfunction

    // stage valid bits: T A B C D E F G H
    logic [8:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[7:0], in_valid};
        end
    end

    // ---------------- stage T: crossing time ----------------
    logic signed [W-1:0] t_reg;
    logic                hit_t_reg;
    logic [1:0]          oc_t_reg;
    logic signed [W-1:0] p_t_reg [3];
    logic signed [W-1:0] v_t_reg [3];
    logic                t_big;

    assign t_big = ovf || (quo > {1'b1, {(W-1){1'b0}}});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg     <= t_big ? VMIN_C[W-1:0] : W'(~quo + W'(1));
            hit_t_reg <= t_big;
            oc_t_reg  <= oc_in;
            p_t_reg   <= p_in;
            v_t_reg   <= v_in;
        end
    end

    // ---------------- stage A: time and restitution products ----------------
    logic signed [2*W-1:0] tv_reg  [3];
    logic signed [W+F+1:0] rsv_reg [3];
    logic                  hit_a_reg;
    logic [1:0]            oc_a_reg;
    logic signed [W-1:0]   p_a_reg [3];
    logic signed [W-1:0]   v_a_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tv_reg[i]  <= t_reg * v_t_reg[i];
                rsv_reg[i] <= $signed({1'b0, rs}) * v_t_reg[i];
            end
            hit_a_reg <= hit_t_reg;
            oc_a_reg  <= oc_t_reg;
            p_a_reg   <= p_t_reg;
            v_a_reg   <= v_t_reg;
        end
    end

    // ---------------- stage B: pulled-back position, reduced velocity ----------------
    logic signed [CW-1:0] np_sum [3];
    logic signed [CW-1:0] r_sum  [3];
    logic [W:0]           np_sat [3];
    logic [W:0]           r_sat  [3];
    logic signed [W-1:0]  np_b_reg [3];
    logic signed [W-1:0]  r_b_reg  [3];
    logic signed [W-1:0]  v_b_reg  [3];
    logic                 hit_b_reg;
    logic [1:0]           oc_b_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            np_sum[i] = CW'(tv_reg[i]);
            np_sum[i] = (np_sum[i] >>> F) + CW'(p_a_reg[i]);
            r_sum[i]  = CW'(rsv_reg[i]);
            r_sum[i]  = CW'(v_a_reg[i]) - (r_sum[i] >>> F);
            np_sat[i] = sat(np_sum[i]);
            r_sat[i]  = sat(r_sum[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                np_b_reg[i] <= (oc_a_reg == OC_DEFLECT) ? np_sat[i][W-1:0] : p_a_reg[i];
                r_b_reg[i]  <= r_sat[i][W-1:0];
            end
            v_b_reg   <= v_a_reg;
            hit_b_reg <= hit_a_reg | np_sat[0][W] | np_sat[1][W] | np_sat[2][W]
                         | r_sat[0][W] | r_sat[1][W] | r_sat[2][W];
            oc_b_reg  <= oc_a_reg;
        end
    end

    // ---------------- stage C: normal products of reduced velocity ----------------
    logic signed [W+F+1:0] nr_reg [3];
    logic signed [W-1:0]   np_c_reg [3];
    logic signed [W-1:0]   r_c_reg  [3];
    logic signed [W-1:0]   v_c_reg  [3];
    logic                  hit_c_reg;
    logic [1:0]            oc_c_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nr_reg[i] <= nrm[i] * r_b_reg[i];
            end
            np_c_reg  <= np_b_reg;
            r_c_reg   <= r_b_reg;
            v_c_reg   <= v_b_reg;
            hit_c_reg <= hit_b_reg;
            oc_c_reg  <= oc_b_reg;
        end
    end

    // ---------------- stage D: normal speed after restitution ----------------
    logic signed [CW-1:0] q_sum;
    logic [W:0]           q_sat;
    logic signed [W-1:0]  q_reg;
    logic signed [W-1:0]  np_d_reg [3];
    logic signed [W-1:0]  r_d_reg  [3];
    logic signed [W-1:0]  v_d_reg  [3];
    logic                 hit_d_reg;
    logic [1:0]           oc_d_reg;

    always_comb
    begin
        q_sum = CW'(nr_reg[0]) + CW'(nr_reg[1]) + CW'(nr_reg[2]);
        q_sat = sat(q_sum >>> F);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg     <= q_sat[W-1:0];
            np_d_reg  <= np_c_reg;
            r_d_reg   <= r_c_reg;
            v_d_reg   <= v_c_reg;
            hit_d_reg <= hit_c_reg | q_sat[W];
            oc_d_reg  <= oc_c_reg;
        end
    end

    // ---------------- stage E: reflection factor product ----------------
    logic [F+1:0]         fac;
    logic signed [W+F+2:0] wq_reg;
    logic signed [W-1:0]  np_e_reg [3];
    logic signed [W-1:0]  r_e_reg  [3];
    logic signed [W-1:0]  v_e_reg  [3];
    logic                 hit_e_reg;
    logic [1:0]           oc_e_reg;

    assign fac = {2'b01, {F{1'b0}}} + {1'b0, fr};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wq_reg    <= $signed({1'b0, fac}) * q_reg;
            np_e_reg  <= np_d_reg;
            r_e_reg   <= r_d_reg;
            v_e_reg   <= v_d_reg;
            hit_e_reg <= hit_d_reg;
            oc_e_reg  <= oc_d_reg;
        end
    end

    // ---------------- stage F: reflected normal speed ----------------
    logic signed [CW-1:0] w_ext;
    logic [W:0]           w_sat;
    logic signed [W-1:0]  w_reg;
    logic signed [W-1:0]  np_f_reg [3];
    logic signed [W-1:0]  r_f_reg  [3];
    logic signed [W-1:0]  v_f_reg  [3];
    logic                 hit_f_reg;
    logic [1:0]           oc_f_reg;

    always_comb
    begin
        w_ext = CW'(wq_reg);
        w_sat = sat(w_ext >>> F);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg     <= w_sat[W-1:0];
            np_f_reg  <= np_e_reg;
            r_f_reg   <= r_e_reg;
            v_f_reg   <= v_e_reg;
            hit_f_reg <= hit_e_reg | w_sat[W];
            oc_f_reg  <= oc_e_reg;
        end
    end

    // ---------------- stage G: reflection along the normal ----------------
    logic signed [W+F+1:0] wn_reg [3];
    logic signed [W-1:0]   np_g_reg [3];
    logic signed [W-1:0]   r_g_reg  [3];
    logic signed [W-1:0]   v_g_reg  [3];
    logic                  hit_g_reg;
    logic [1:0]            oc_g_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                wn_reg[i] <= w_reg * nrm[i];
            end
            np_g_reg  <= np_f_reg;
            r_g_reg   <= r_f_reg;
            v_g_reg   <= v_f_reg;
            hit_g_reg <= hit_f_reg;
            oc_g_reg  <= oc_f_reg;
        end
    end

    // ---------------- stage H: new velocity and output register ----------------
    logic signed [CW-1:0] nv_sum [3];
    logic [W:0]           nv_sat [3];
    logic                 deflect;
    logic                 hit_h;

    assign deflect = (oc_g_reg == OC_DEFLECT);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nv_sum[i] = CW'(wn_reg[i]);
            nv_sum[i] = CW'(r_g_reg[i]) - (nv_sum[i] >>> F);
            nv_sat[i] = sat(nv_sum[i]);
        end
        hit_h = hit_g_reg | nv_sat[0][W] | nv_sat[1][W] | nv_sat[2][W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                new_vel[i] <= deflect ? nv_sat[i][W-1:0] : v_g_reg[i];
            end
            new_pos   <= np_g_reg;
            kill      <= (oc_g_reg == OC_KILLED);
            outcome   <= oc_g_reg;
            saturated <= deflect & hit_h;
        end
    end

    assign out_valid = vld_reg[8];

endmodule

`default_nettype wire

@@ rtl/core/plpb_checker.sv @@
// ----------------------------------------------------------------------------
// plpb_checker
// Port-level checks of the bounce pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plpb_checker
    import plpb_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       kill,
    input wire logic [1:0] outcome,
    input wire logic       saturated
);

    // a stalled output word keeps its valid, outcome and kill flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(outcome) && $stable(kill))
        else $error("stalled output word changed");

    // input stalls exactly while the output word is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output hold");

    // kill flag matches the killed outcome
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kill == (outcome == OC_KILLED)))
        else $error("kill flag disagrees with outcome");

    // clamping is reported only for deflections
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (outcome == OC_DEFLECT))
        else $error("saturated set outside a deflection");

endmodule

bind particle_plane_bounce plpb_checker u_plpb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kill      (kill),
    .outcome   (outcome),
    .saturated (saturated)
);

`default_nettype wire
